[rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared codes, field widths and control types of the k-way sorted merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int LANE_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int ACT_W      = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_OFFER  = 2'd0;
  localparam logic [OP_W-1:0] OP_END    = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE   = 2'd2;
  localparam logic [OP_W-1:0] OP_RESCAN = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FINISHED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LANES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_LEAD    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING   = 4'd2;

  // register reset values
  localparam logic [ACT_W-1:0] ACTIVE_LANES_RST = 5'd16;

  // lane state update request, one item per cycle unless a take is stalled
  typedef struct packed {
    logic offer;    // write the addressed lane's head
    logic finish;   // mark the addressed lane ended
    logic clear;    // drop all heads and end marks
    logic consume;  // drop the winning lane's head
  } kwm_upd_t;

endpackage

[rtl/kwm_in_if.sv]
// ----------------------------------------------------------------------------
// kwm_in_if
// Request channel: operation, lane and offered record.
// ----------------------------------------------------------------------------
interface kwm_in_if
  import kwm_pkg::*;
#(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [LANE_W-1:0]   lane;
  logic [KEY_BITS-1:0] record_key;
  logic                record_null;
  logic [TAG_BITS-1:0] record_tag;

  modport source (output valid, operation, lane, record_key, record_null, record_tag,
                  input ready);
  modport sink   (input valid, operation, lane, record_key, record_null, record_tag,
                  output ready);
endinterface

[rtl/kwm_out_if.sv]
// ----------------------------------------------------------------------------
// kwm_out_if
// Result channel: status, winning lane and delivered record.
// ----------------------------------------------------------------------------
interface kwm_out_if
  import kwm_pkg::*;
#(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LANE_W-1:0]   winner_lane;
  logic [KEY_BITS-1:0] out_key;
  logic                out_null;
  logic [TAG_BITS-1:0] out_tag;

  modport source (output valid, status, winner_lane, out_key, out_null, out_tag,
                  input ready);
  modport sink   (input valid, status, winner_lane, out_key, out_null, out_tag,
                  output ready);
endinterface

[rtl/kwm_cfg_if.sv]
// ----------------------------------------------------------------------------
// kwm_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface kwm_cfg_if
  import kwm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/k_way_sorted_merge_top.sv]
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top
// Path: a take is held in the input register, then its result is loaded
//   into the result register.
// Throughput: one item per cycle; set by the combinational min tree over the
//   head registers, whose outcome updates the lane state at the same edge.
//   A take waits in the input register while an earlier result is stalled.
// Reset (rst_n, synchronous): clears end marks and all valid flags, the
//   channel ones too, and restores register defaults; no payload is reset.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_top
  import kwm_pkg::*;
#(
  parameter int LANES    = 16,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  kwm_in_if.sink    in_ch,
  kwm_out_if.source out_ch,
  kwm_cfg_if.sink   cfg_ch
);

  localparam int LIDX_W = $clog2(LANES);

  // configuration registers
  logic [ACT_W-1:0] active_r;
  logic             null_lead_r;
  logic             descending_r;

  // input register
  logic                in_vld_r;
  logic [OP_W-1:0]     op_r;
  logic [LANE_W-1:0]   lane_r;
  logic [KEY_BITS-1:0] key_r;
  logic                null_r;
  logic [TAG_BITS-1:0] tag_r;

  // result register
  logic                out_vld_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [LANE_W-1:0]   winner_r, winner_nxt;
  logic [KEY_BITS-1:0] okey_r, okey_nxt;
  logic                onull_r, onull_nxt;
  logic [TAG_BITS-1:0] otag_r, otag_nxt;

  logic                is_take;
  logic                advance;
  logic                lane_ok;
  logic [LIDX_W+LANE_W-1:0] lane_wide;
  logic [LIDX_W-1:0]   lane_idx;
  kwm_upd_t            upd;

  logic [KEY_BITS-1:0] head_key [LANES];
  logic [LANES-1:0]    head_null;
  logic [LANES-1:0]    head_valid;
  logic [LANES-1:0]    lane_done;
  logic                miss_any;
  logic [LIDX_W-1:0]   miss_lane;
  logic                found;
  logic [LIDX_W-1:0]   win_lane;
  logic [KEY_BITS-1:0] win_key;
  logic                win_null;
  logic [TAG_BITS-1:0] win_tag;
  logic [LIDX_W+LANE_W-1:0] miss_wide;
  logic [LIDX_W+LANE_W-1:0] win_wide;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= ACTIVE_LANES_RST;
      null_lead_r  <= 1'b0;
      descending_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ACTIVE_LANES: active_r     <= cfg_ch.data[ACT_W-1:0];
        REG_NULL_LEAD:    null_lead_r  <= cfg_ch.data[0];
        REG_DESCENDING:   descending_r <= cfg_ch.data[0];
        default:          ;
      endcase
    end
  end

  // the held item moves on unless it is a take blocked by a full result
  assign is_take     = (op_r == OP_TAKE);
  assign advance     = in_vld_r & (~is_take | ~out_vld_r | out_ch.ready);
  assign in_ch.ready = ~in_vld_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r   <= in_ch.operation;
      lane_r <= in_ch.lane;
      key_r  <= in_ch.record_key;
      null_r <= in_ch.record_null;
      tag_r  <= in_ch.record_tag;
    end
  end

  // lane address, out-of-range lanes are ignored
  assign lane_ok   = (32'(lane_r) < LANES);
  assign lane_wide = {{LIDX_W{1'b0}}, lane_r};
  assign lane_idx  = lane_wide[LIDX_W-1:0];

  always_comb begin
    upd         = '0;
    upd.offer   = advance & (op_r == OP_OFFER) & lane_ok;
    upd.finish  = advance & (op_r == OP_END) & lane_ok;
    upd.clear   = advance & (op_r == OP_RESCAN);
    upd.consume = advance & is_take & ~miss_any & found;
  end

  kwm_lane_store #(
    .LANES(LANES), .KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS), .LIDX_W(LIDX_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .wr_lane    (lane_idx),
    .wr_key     (key_r),
    .wr_null    (null_r),
    .wr_tag     (tag_r),
    .win_lane   (win_lane),
    .head_key   (head_key),
    .head_null  (head_null),
    .head_valid (head_valid),
    .lane_done  (lane_done),
    .win_tag    (win_tag)
  );

  kwm_select #(
    .LANES(LANES), .KEY_BITS(KEY_BITS), .LIDX_W(LIDX_W)
  ) u_select (
    .active_lanes (active_r),
    .null_lead    (null_lead_r),
    .descending   (descending_r),
    .head_key     (head_key),
    .head_null    (head_null),
    .head_valid   (head_valid),
    .lane_done    (lane_done),
    .miss_any     (miss_any),
    .miss_lane    (miss_lane),
    .found        (found),
    .win_lane     (win_lane),
    .win_key      (win_key),
    .win_null     (win_null)
  );

  // result fields
  assign miss_wide = {{LANE_W{1'b0}}, miss_lane};
  assign win_wide  = {{LANE_W{1'b0}}, win_lane};

  always_comb begin
    status_nxt = ST_DELIVERED;
    winner_nxt = '0;
    okey_nxt   = '0;
    onull_nxt  = 1'b0;
    otag_nxt   = '0;
    if (miss_any) begin
      status_nxt = ST_MISSING;
      winner_nxt = miss_wide[LANE_W-1:0];
    end else if (!found) begin
      status_nxt = ST_FINISHED;
    end else begin
      winner_nxt = win_wide[LANE_W-1:0];
      okey_nxt   = win_key;
      onull_nxt  = win_null;
      otag_nxt   = win_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && is_take) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_take) begin
      status_r <= status_nxt;
      winner_r <= winner_nxt;
      okey_r   <= okey_nxt;
      onull_r  <= onull_nxt;
      otag_r   <= otag_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = status_r;
  assign out_ch.winner_lane = winner_r;
  assign out_ch.out_key     = okey_r;
  assign out_ch.out_null    = onull_r;
  assign out_ch.out_tag     = otag_r;

endmodule

[rtl/kwm_lane_store.sv]
// ----------------------------------------------------------------------------
// kwm_lane_store
// Per-lane head registers with valid and end marks; reads the winner's tag.
// ----------------------------------------------------------------------------
module kwm_lane_store
  import kwm_pkg::*;
#(
  parameter int LANES    = 16,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16,
  parameter int LIDX_W   = $clog2(LANES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kwm_upd_t            upd,
  input  logic [LIDX_W-1:0]   wr_lane,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic                wr_null,
  input  logic [TAG_BITS-1:0] wr_tag,
  input  logic [LIDX_W-1:0]   win_lane,
  output logic [KEY_BITS-1:0] head_key   [LANES],
  output logic [LANES-1:0]    head_null,
  output logic [LANES-1:0]    head_valid,
  output logic [LANES-1:0]    lane_done,
  output logic [TAG_BITS-1:0] win_tag
);

  logic [KEY_BITS-1:0] key_r  [LANES];
  logic [TAG_BITS-1:0] tag_r  [LANES];
  logic [LANES-1:0]    null_r;
  logic [LANES-1:0]    valid_r;
  logic [LANES-1:0]    done_r;

  // lane control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      done_r  <= '0;
    end else if (upd.clear) begin
      valid_r <= '0;
      done_r  <= '0;
    end else begin
      if (upd.offer) begin
        valid_r[wr_lane] <= 1'b1;
        done_r[wr_lane]  <= 1'b0;
      end
      if (upd.finish) begin
        valid_r[wr_lane] <= 1'b0;
        done_r[wr_lane]  <= 1'b1;
      end
      if (upd.consume) begin
        valid_r[win_lane] <= 1'b0;
      end
    end
  end

  // head payload, no reset
  always_ff @(posedge clk) begin
    if (upd.offer) begin
      key_r[wr_lane]  <= wr_key;
      null_r[wr_lane] <= wr_null;
      tag_r[wr_lane]  <= wr_tag;
    end
  end

  assign head_key   = key_r;
  assign head_null  = null_r;
  assign head_valid = valid_r;
  assign lane_done  = done_r;
  assign win_tag    = tag_r[win_lane];

endmodule

[rtl/kwm_select.sv]
// ----------------------------------------------------------------------------
// kwm_select
// Finds the lowest missing lane and the first head in merge order.
// ----------------------------------------------------------------------------
module kwm_select
  import kwm_pkg::*;
#(
  parameter int LANES    = 16,
  parameter int KEY_BITS = 32,
  parameter int LIDX_W   = $clog2(LANES)
) (
  input  logic [ACT_W-1:0]    active_lanes,
  input  logic                null_lead,
  input  logic                descending,
  input  logic [KEY_BITS-1:0] head_key   [LANES],
  input  logic [LANES-1:0]    head_null,
  input  logic [LANES-1:0]    head_valid,
  input  logic [LANES-1:0]    lane_done,
  output logic                miss_any,
  output logic [LIDX_W-1:0]   miss_lane,
  output logic                found,
  output logic [LIDX_W-1:0]   win_lane,
  output logic [KEY_BITS-1:0] win_key,
  output logic                win_null
);

  localparam int LEAVES = 1 << LIDX_W;

  typedef struct packed {
    logic                vld;
    logic                nul;
    logic [KEY_BITS-1:0] key;
    logic [LIDX_W-1:0]   idx;
  } node_t;

  logic [LANES-1:0] act;
  logic [LANES-1:0] miss;
  node_t            node [1:2*LEAVES-1];

  // true if b goes strictly before a
  function automatic logic goes_first(node_t b, node_t a, logic nf, logic desc);
    logic res;
    if (b.nul || a.nul) begin
      if (b.nul && a.nul) res = 1'b0;
      else                res = b.nul ? nf : !nf;
    end else if (b.key == a.key) begin
      res = 1'b0;
    end else begin
      res = desc ? (b.key > a.key) : (b.key < a.key);
    end
    return res;
  endfunction

  // leaves: active lanes holding a head
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < LANES) begin : g_real
      assign act[i]  = (32'(i) < 32'(active_lanes));
      assign miss[i] = act[i] & ~head_valid[i] & ~lane_done[i];
      assign node[LEAVES+i] = '{vld: head_valid[i] & act[i], nul: head_null[i],
                                key: head_key[i], idx: LIDX_W'(i)};
    end else begin : g_pad
      assign node[LEAVES+i] = '{vld: 1'b0, nul: 1'b0, key: '0, idx: '0};
    end
  end

  // min tree, lower lane keeps ties
  for (genvar n = LEAVES - 1; n >= 1; n--) begin : g_node
    assign node[n] = (node[2*n+1].vld &&
                      (!node[2*n].vld ||
                       goes_first(node[2*n+1], node[2*n], null_lead, descending)))
                     ? node[2*n+1] : node[2*n];
  end

  // lowest lane missing its head
  always_comb begin
    miss_any  = 1'b0;
    miss_lane = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (miss[i]) begin
        miss_any  = 1'b1;
        miss_lane = LIDX_W'(i);
      end
    end
  end

  assign found    = node[1].vld;
  assign win_lane = node[1].idx;
  assign win_key  = node[1].key;
  assign win_null = node[1].nul;

endmodule

[rtl/kwm_checker.sv]
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks of the merge block, bound to the top level.
// ----------------------------------------------------------------------------
module kwm_checker
  import kwm_pkg::*;
#(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OP_W-1:0]     in_op,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [LANE_W-1:0]   winner_lane,
  input logic [KEY_BITS-1:0] out_key,
  input logic                out_null,
  input logic [TAG_BITS-1:0] out_tag
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({status, winner_lane, out_key, out_null, out_tag}))
    else $error("result changed while stalled");

  // a fresh result follows an accepted take request
  a_rise_from_take: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_op == OP_TAKE), 2))
    else $error("result without a take request");

  // finished carries no record and no lane
  a_finished_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FINISHED) |->
      (winner_lane == '0) && (out_key == '0) && !out_null && (out_tag == '0))
    else $error("finished status with record fields set");

  // missing head carries no record
  a_missing_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_MISSING) |->
      (out_key == '0) && !out_null && (out_tag == '0))
    else $error("missing status with record fields set");

endmodule

bind k_way_sorted_merge_top kwm_checker #(
  .KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)
) u_kwm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_op       (in_ch.operation),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .winner_lane (out_ch.winner_lane),
  .out_key     (out_ch.out_key),
  .out_null    (out_ch.out_null),
  .out_tag     (out_ch.out_tag)
);
